### rtl/ucpp_pkg.sv
`default_nettype none

package ucpp_pkg;

   // Width of the decimal timer setting (up to 9999).
   localparam int TIMER_W = 14;

   // Characters that frame and spell a command packet.
   localparam logic [7:0] CHAR_LT   = 8'h3C;  // '<'
   localparam logic [7:0] CHAR_GT   = 8'h3E;  // '>'
   localparam logic [7:0] CHAR_L    = 8'h4C;  // 'L'
   localparam logic [7:0] CHAR_T    = 8'h54;  // 'T'
   localparam logic [7:0] CHAR_E    = 8'h45;  // 'E'
   localparam logic [7:0] CHAR_O    = 8'h4F;  // 'O'
   localparam logic [7:0] CHAR_F    = 8'h46;  // 'F'
   localparam logic [7:0] CHAR_N    = 8'h4E;  // 'N'
   localparam logic [7:0] CHAR_ZERO = 8'h30;  // '0'
   localparam logic [7:0] CHAR_NINE = 8'h39;  // '9'

   // What an input word carries.
   typedef enum logic [1:0] {
      MODE_RX_BYTE       = 2'd0,
      MODE_TIMER_EXPIRED = 2'd1,
      MODE_EMERGENCY     = 2'd2,
      MODE_NOP           = 2'd3
   } mode_type;

   // Event reported with each result word.
   typedef enum logic [3:0] {
      EV_NONE          = 4'd0,
      EV_LOCK          = 4'd1,
      EV_UNLOCK        = 4'd2,
      EV_TIMER_START   = 4'd3,
      EV_LOCKED_REJECT = 4'd4,
      EV_OVERFLOW      = 4'd5,
      EV_TIMER_STOP    = 4'd6,
      EV_OPEN          = 4'd7,
      EV_EMERGENCY_END = 4'd8,
      EV_PACKET_ERROR  = 4'd9,
      EV_IGNORED       = 4'd10
   } event_type;

   // Shared lock, timer and emergency state.
   typedef struct packed {
      logic               lock;
      logic               enable;
      logic               running;
      logic               done;
      logic               emergency;
      logic [TIMER_W-1:0] set_value;
   } timer_state_type;

endpackage

`default_nettype wire

### rtl/ucpp_decode.sv
`default_nettype none

module ucpp_decode
   import ucpp_pkg::*;
#(
   parameter int MAX_DIGITS = 4,
   parameter int PKT_BYTES  = 7
) (
   input  logic [7:0]      pkt [PKT_BYTES],
   input  timer_state_type state_cur,
   output timer_state_type state_nxt,
   output event_type       event_code
);

   logic [TIMER_W-1:0] digit_acc;
   logic               digit_end;
   logic               digit_bad;
   logic               digit_full;

   // Accumulate up to MAX_DIGITS decimal digits after the 'T', stopping at '>'.
   always_comb begin
      digit_acc = '0;
      digit_end = 1'b0;
      digit_bad = 1'b0;
      for (int k = 0; k < MAX_DIGITS; k++) begin
         if (!digit_end && !digit_bad) begin
            if (pkt[2+k] == CHAR_GT) begin
               digit_end = 1'b1;
            end else if (pkt[2+k] < CHAR_ZERO || pkt[2+k] > CHAR_NINE) begin
               digit_bad = 1'b1;
            end else begin
               digit_acc = (digit_acc << 3) + (digit_acc << 1)
                         + TIMER_W'(pkt[2+k] - CHAR_ZERO);
            end
         end
      end
      digit_full = !digit_end && !digit_bad;
   end

   // Decode the command letter and update the shared state.
   always_comb begin
      state_nxt  = state_cur;
      event_code = EV_PACKET_ERROR;
      priority if (pkt[1] == CHAR_O) begin
         event_code = EV_OPEN;
      end else if (pkt[1] == CHAR_L) begin
         priority if (pkt[4] == CHAR_F) begin
            state_nxt.lock   = 1'b1;
            state_nxt.enable = 1'b0;
            event_code       = EV_LOCK;
         end else if (pkt[4] == CHAR_N) begin
            state_nxt.lock   = 1'b0;
            state_nxt.enable = 1'b1;
            event_code       = EV_UNLOCK;
         end else begin
            event_code = EV_IGNORED;
         end
      end else if (pkt[1] == CHAR_T) begin
         priority if (pkt[2] == CHAR_O) begin
            state_nxt.enable    = 1'b0;
            state_nxt.running   = 1'b0;
            state_nxt.done      = 1'b0;
            state_nxt.set_value = '0;
            event_code          = EV_TIMER_STOP;
         end else if (state_cur.running || pkt[2] == CHAR_GT) begin
            event_code = EV_IGNORED;
         end else if (state_cur.lock) begin
            event_code = EV_LOCKED_REJECT;
         end else begin
            // The digits taken so far are kept even when the packet is refused.
            state_nxt.set_value = digit_acc;
            priority if (digit_bad) begin
               event_code = EV_IGNORED;
            end else if (digit_full && pkt[2+MAX_DIGITS] != CHAR_GT) begin
               event_code = EV_OVERFLOW;
            end else begin
               state_nxt.enable  = 1'b1;
               state_nxt.running = 1'b1;
               state_nxt.done    = 1'b0;
               event_code        = EV_TIMER_START;
            end
         end
      end else if (pkt[1] == CHAR_E) begin
         if (pkt[2] == CHAR_O) begin
            state_nxt.emergency = 1'b0;
            state_nxt.lock      = 1'b0;
            event_code          = EV_EMERGENCY_END;
         end else begin
            event_code = EV_IGNORED;
         end
      end else begin
         event_code = EV_PACKET_ERROR;
      end
   end

endmodule

`default_nettype wire

### rtl/uart_command_packet_parser.sv
// Command packet parser for bytes received on two links (wired console on channel 0,
// wireless link on channel 1). Each input word is a received byte, a timer-expired
// event, an emergency-raised event or a no-op, selected by req_tuser; every input
// word yields exactly one result word with the echoed byte, an event code and the
// lock, timer and emergency flags after that word. Each channel collects its own
// packet, which must start with '<' and is dropped when it reaches PACKET_LIMIT
// bytes; '>' decodes it. A word is accepted every cycle unless the result register
// is stalled by a low rsp_tready; its result passes through the input register,
// then the result register. The per-channel packet registers and shared flag
// registers are updated in the same cycle as the result register is loaded.
`default_nettype none

module uart_command_packet_parser
   import ucpp_pkg::*;
#(
   parameter int PACKET_LIMIT = 10,
   parameter int MAX_DIGITS   = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [2:0]  req_tuser,   // [1:0] mode, [2] channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [7:0] echo_byte, [11:8] event_code,
                                    // [25:12] timer_value, [26] sensor_lock,
                                    // [27] timer_enabled, [28] timer_running,
                                    // [29] timer_finished, [30] emergency_active,
                                    // [31] zero
);

   // Only the bytes that the decode looks at are kept.
   localparam int PKT_BYTES = (MAX_DIGITS + 3 > 5) ? MAX_DIGITS + 3 : 5;
   localparam int FILL_W    = $clog2(PACKET_LIMIT + 1);

   logic                in_valid_ff;
   logic [1:0]          in_mode_ff;
   logic                in_chan_ff;
   logic [7:0]          in_byte_ff;
   logic                rsp_valid_ff;
   logic [31:0]         rsp_data_ff;
   logic [7:0]          pkt_ff [2][PKT_BYTES];
   logic [FILL_W-1:0]   fill_ff [2];
   timer_state_type     tstate_ff;
   timer_state_type     tstate_in;
   timer_state_type     dec_state;
   event_type           dec_event;
   event_type           ev_in;
   logic [7:0]          echo_in;
   logic                advance;
   logic                step;
   logic                is_rx;
   logic                is_gt;
   logic [FILL_W-1:0]   fill_cur;
   logic [FILL_W-1:0]   fill_inc;
   logic                pkt_clear;
   logic [7:0]          pkt_pre [PKT_BYTES];
   logic [7:0]          pkt_eff [PKT_BYTES];

   // Handshake: the result register frees the input register when it can take a word.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign step       = in_valid_ff && advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         in_mode_ff <= req_tuser[1:0];
         in_chan_ff <= req_tuser[2];
         in_byte_ff <= req_tdata;
      end
   end

   // Store the byte in its channel's packet, then drop the packet if it is full
   // or does not open with '<'.
   assign is_rx    = (mode_type'(in_mode_ff) == MODE_RX_BYTE);
   assign is_gt    = (in_byte_ff == CHAR_GT);
   assign fill_cur = fill_ff[in_chan_ff];
   assign fill_inc = fill_cur + FILL_W'(1);

   always_comb begin
      for (int i = 0; i < PKT_BYTES; i++) begin
         pkt_pre[i] = (fill_cur == FILL_W'(i)) ? in_byte_ff : pkt_ff[in_chan_ff][i];
      end
      pkt_clear = (fill_inc >= FILL_W'(PACKET_LIMIT)) || (pkt_pre[0] != CHAR_LT);
      for (int i = 0; i < PKT_BYTES; i++) begin
         pkt_eff[i] = pkt_clear ? 8'h00 : pkt_pre[i];
      end
   end

   ucpp_decode #(
      .MAX_DIGITS (MAX_DIGITS),
      .PKT_BYTES  (PKT_BYTES)
   ) u_decode (
      .pkt        (pkt_eff),
      .state_cur  (tstate_ff),
      .state_nxt  (dec_state),
      .event_code (dec_event)
   );

   // Apply the word to the shared state.
   always_comb begin
      tstate_in = tstate_ff;
      ev_in     = EV_NONE;
      echo_in   = 8'h00;
      unique case (mode_type'(in_mode_ff))
         MODE_RX_BYTE: begin
            echo_in = in_byte_ff;
            if (is_gt) begin
               tstate_in = dec_state;
               ev_in     = dec_event;
            end
         end
         MODE_TIMER_EXPIRED: begin
            if (tstate_ff.running) begin
               tstate_in.running = 1'b0;
               tstate_in.done    = 1'b1;
            end
         end
         MODE_EMERGENCY: begin
            tstate_in.emergency = 1'b1;
            tstate_in.lock      = 1'b1;
         end
         MODE_NOP: begin
            tstate_in = tstate_ff;
         end
         default: begin
            tstate_in = tstate_ff;
         end
      endcase
   end

   // Packet buffers, fill counts and shared flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < 2; c++) begin
            fill_ff[c] <= '0;
            for (int i = 0; i < PKT_BYTES; i++) begin
               pkt_ff[c][i] <= 8'h00;
            end
         end
         tstate_ff <= '0;
      end else if (step) begin
         tstate_ff <= tstate_in;
         if (is_rx) begin
            fill_ff[in_chan_ff] <= (pkt_clear || is_gt) ? '0 : fill_inc;
            for (int i = 0; i < PKT_BYTES; i++) begin
               pkt_ff[in_chan_ff][i] <= is_gt ? 8'h00 : pkt_eff[i];
            end
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
      if (step) begin
         rsp_data_ff <= {1'b0, tstate_in.emergency, tstate_in.done, tstate_in.running,
                         tstate_in.enable, tstate_in.lock, tstate_in.set_value,
                         ev_in, echo_in};
      end
   end

endmodule

`default_nettype wire
